[src/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned MAXP_W = 16;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned CNT_W  = 4;

	localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 16'd1024;

	// Header values
	localparam logic [BYTE_W-1:0] HDR_FIN_TEXT = 8'h81;
	localparam logic [6:0]        LEN_EXT16    = 7'd126;
	localparam logic [6:0]        LEN_EXT64    = 7'd127;

	// Byte counts of the extended length and key fields
	localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
	localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
	localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_CLOSE = 2'd2
	} kind_t;

	typedef enum logic [6:0] {
		PH_HDR0   = 7'b0000001,
		PH_HDR1   = 7'b0000010,
		PH_EXT16  = 7'b0000100,
		PH_EXT64  = 7'b0001000,
		PH_KEY    = 7'b0010000,
		PH_DATA   = 7'b0100000,
		PH_CLOSED = 7'b1000000
	} phase_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload_byte;
		logic              last_in_message;
	} res_t;

endpackage

[src/wsd_in_stage.sv]
// Input register of the deframer: holds one received byte until it is parsed.
// Depends on wsd_pkg.
module wsd_in_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [wsd_pkg::BYTE_W-1:0] s_tdata,  // [7:0] stream_byte
	input  logic                      advance,
	output logic                      valid_s1,
	output logic [wsd_pkg::BYTE_W-1:0] byte_s1
);
	import wsd_pkg::*;

	logic vld_s1;

	// a new word may enter when the slot is empty or is drained this cycle
	assign s_tready = !vld_s1 || advance;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

[src/wsd_parser.sv]
// Frame parser: header, length and key state plus payload unmasking.
// Holds the max_payload register. Depends on wsd_pkg.
module wsd_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr,
	input  logic [wsd_pkg::MAXP_W-1:0] cfg_data,
	input  logic                       advance,
	input  logic [wsd_pkg::BYTE_W-1:0] byte_s1,
	output logic                       res_valid,
	output wsd_pkg::res_t              res
);
	import wsd_pkg::*;

	phase_t             phase_q, phase_n;
	logic [CNT_W-1:0]   fcnt_q, fcnt_n, fcnt_inc;
	logic [LEN_W-1:0]   len_q, len_n;
	logic               ovf_q, ovf_n;
	logic [KEY_W-1:0]   key_q, key_n;
	logic [LEN_W-1:0]   idx_q, idx_n;
	logic [MAXP_W-1:0]  maxp_q;
	logic [BYTE_W-1:0]  key_byte;
	logic               last;

	assign fcnt_inc = fcnt_q + 4'd1;

	always_comb begin
		unique case (idx_q[1:0])
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
		endcase
	end

	assign last = ({1'b0, idx_q} + 17'd1) >= {1'b0, len_q};

	always_comb begin
		phase_n   = phase_q;
		fcnt_n    = fcnt_q;
		len_n     = len_q;
		ovf_n     = ovf_q;
		key_n     = key_q;
		idx_n     = idx_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_DATA, payload_byte: '0, last_in_message: 1'b0};
		unique case (phase_q)
			PH_HDR0: begin
				if (byte_s1 != HDR_FIN_TEXT) begin
					phase_n   = PH_CLOSED;
					res_valid = 1'b1;
					res.kind  = KIND_CLOSE;
				end else begin
					phase_n = PH_HDR1;
				end
			end
			PH_HDR1: begin
				fcnt_n = '0;
				ovf_n  = 1'b0;
				key_n  = '0;
				idx_n  = '0;
				len_n  = '0;
				if (byte_s1[6:0] == LEN_EXT16) begin
					phase_n = PH_EXT16;
				end else if (byte_s1[6:0] == LEN_EXT64) begin
					phase_n = PH_EXT64;
				end else begin
					len_n   = {9'd0, byte_s1[6:0]};
					phase_n = PH_KEY;
				end
			end
			PH_EXT16: begin
				len_n  = {len_q[7:0], byte_s1};
				fcnt_n = fcnt_inc;
				if (fcnt_inc >= EXT16_BYTES) begin
					fcnt_n  = '0;
					phase_n = PH_KEY;
				end
			end
			PH_EXT64: begin
				// only the low 16 bits are kept; anything shifted out is overflow
				ovf_n  = ovf_q | (len_q[15:8] != 8'd0);
				len_n  = {len_q[7:0], byte_s1};
				fcnt_n = fcnt_inc;
				if (fcnt_inc >= EXT64_BYTES) begin
					fcnt_n = '0;
					if (ovf_n || (len_n > maxp_q)) begin
						phase_n   = PH_CLOSED;
						res_valid = 1'b1;
						res.kind  = KIND_CLOSE;
					end else begin
						phase_n = PH_KEY;
					end
				end
			end
			PH_KEY: begin
				key_n  = {key_q[23:0], byte_s1};
				fcnt_n = fcnt_inc;
				if (fcnt_inc >= KEY_BYTES) begin
					fcnt_n = '0;
					idx_n  = '0;
					if (len_q == '0) begin
						phase_n             = PH_HDR0;
						res_valid           = 1'b1;
						res.kind            = KIND_EMPTY;
						res.last_in_message = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				idx_n               = idx_q + 16'd1;
				res_valid           = 1'b1;
				res.payload_byte    = byte_s1 ^ key_byte;
				res.last_in_message = last;
				if (last) begin
					phase_n = PH_HDR0;
				end
			end
			default: begin
				// closed: drop everything until reset
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			fcnt_q  <= '0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			key_q   <= '0;
			idx_q   <= '0;
			maxp_q  <= MAX_PAYLOAD_RST;
		end else begin
			if (advance) begin
				phase_q <= phase_n;
				fcnt_q  <= fcnt_n;
				len_q   <= len_n;
				ovf_q   <= ovf_n;
				key_q   <= key_n;
				idx_q   <= idx_n;
			end
			if (cfg_wr) begin
				maxp_q <= cfg_data;
			end
		end
	end

endmodule

[src/wsd_out_reg.sv]
// Result register of the deframer: holds one output word until taken.
// Depends on wsd_pkg.
module wsd_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  logic                        res_valid,
	input  wsd_pkg::res_t               res,
	output logic                        advance,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [wsd_pkg::BYTE_W-1:0]  m_tdata,  // [7:0] payload_byte
	output logic [wsd_pkg::KIND_W-1:0]  m_tuser,  // [1:0] kind
	output logic                        m_tlast   // last_in_message
);
	import wsd_pkg::*;

	logic vld_s2;
	res_t res_s2;

	// the parsed byte moves on once the result slot is free or drains now
	assign advance  = valid_s1 && (!vld_s2 || m_tready);
	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2.payload_byte;
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.last_in_message;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= res_valid;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

[src/websocket_frame_deframer.sv]
// Top level of the WebSocket client-to-server frame deframer.
// Instantiates wsd_in_stage, wsd_parser and wsd_out_reg; uses wsd_pkg.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata[7:0] stream_byte
//  m_*      out  m_tvalid/m_tready   m_tdata[7:0] payload_byte, m_tuser[1:0] kind,
//                                    m_tlast last_in_message
//  cfg_*    in   cfg_valid/cfg_ready cfg_data[15:0] max_payload
//
// One byte per cycle sustained while the result slot drains; a byte is held in the
// input register while parsed; the result register holds its word on m_*.
// The state update and unmasking for a byte sit between the input and result
// registers. A stalled m_tready stalls the parser only when the result slot
// is full. cfg_ready is always high. arst_n restores max_payload to 1024 and
// the parser to waiting for a header; a close request holds until reset.
module websocket_frame_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [wsd_pkg::BYTE_W-1:0]  s_tdata,  // [7:0] stream_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [wsd_pkg::BYTE_W-1:0]  m_tdata,  // [7:0] payload_byte
	output logic [wsd_pkg::KIND_W-1:0]  m_tuser,  // [1:0] kind
	output logic                        m_tlast,  // last_in_message
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wsd_pkg::MAXP_W-1:0]  cfg_data  // [15:0] max_payload
);
	import wsd_pkg::*;

	logic              advance;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              res_valid;
	res_t              res;

	assign cfg_ready = 1'b1;

	wsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

[src/wsd_checker.sv]
// Port-level checks on the deframer's result stream, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer.
module wsd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [wsd_pkg::BYTE_W-1:0]  m_tdata,
	input  logic [wsd_pkg::KIND_W-1:0]  m_tuser,
	input  logic                        m_tlast
);
	import wsd_pkg::*;

	// a close request is the final word until reset
	a_close_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (m_tuser == KIND_CLOSE) |=> !m_tvalid)
		else $error("word after close request");

	a_close_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_CLOSE) |-> !m_tlast && (m_tdata == '0))
		else $error("close request with data or last set");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_EMPTY) |-> m_tlast && (m_tdata == '0))
		else $error("empty message without last or with data");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_DATA) || (m_tuser == KIND_EMPTY) ||
			(m_tuser == KIND_CLOSE))
		else $error("undefined kind");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled word changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
